### rtl/core/perspective_point_projection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perspective point projection block
// Implication checks sampled on the rising clock edge, masked during reset.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// check that post holds in the same cycle as pre
`define PPP_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ppp: same-cycle check failed");

// check that post holds in the cycle after pre
`define PPP_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ppp: next-cycle check failed");

`endif

### rtl/core/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Perspective point projection package
// Widths, register indexes, payload types and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppp_pkg;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 48;
   localparam int CoefW    = 16;
   localparam int PtW      = 16;
   localparam int PixW     = 16;
   localparam int ProdW    = 32;   // coefficient times coordinate
   localparam int AccW     = 34;   // sum of three products
   localparam int RotW     = 20;   // rotated component, Q.10
   localparam int DenFullW = 21;   // signed denominator
   localparam int DenW     = 19;   // positive denominator magnitude
   localparam int GainW    = 24;
   localparam int EyeW     = 18;
   localparam int OrgW     = 10;
   localparam int AspW     = 9;
   localparam int PgW      = 45;   // gain times rotated component
   localparam int Pg2W     = 55;   // gain times component times aspect
   localparam int Num1W    = 35;
   localparam int Num2W    = 37;
   localparam int MagW     = 36;   // dividend magnitude
   localparam int QBits    = 17;   // quotient bits before saturation
   localparam int SumW     = 20;
   localparam int FrontStg = 5;
   localparam int NumStg   = FrontStg + QBits + 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROT_ROW0     = 3'd0,
      CSR_ROT_ROW1     = 3'd1,
      CSR_ROT_ROW2     = 3'd2,
      CSR_EYE_DISTANCE = 3'd3,
      CSR_PROJ_GAIN    = 3'd4,
      CSR_SCREEN_X_ORG = 3'd5,
      CSR_SCREEN_Y_ORG = 3'd6,
      CSR_VERT_ASPECT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [PtW-1:0] point_x;
      logic signed [PtW-1:0] point_y;
      logic signed [PtW-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [PixW-1:0] pixel_col;
      logic signed [PixW-1:0] pixel_row;
      logic                   behind_eye;
   } rsp_payload_type;

   // clamp a widened pixel value to 16 bits
   function automatic logic signed [PixW-1:0] sat_pix(input logic signed [SumW-1:0] v);
      logic signed [PixW-1:0] r;
      if (v > SumW'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -SumW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[PixW-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/ppp_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One payload per transfer; transfer when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/perspective_point_projection.sv
// ----------------------------------------------------------------------------
// Perspective point projection
// Rotates a 3D point, divides by depth and maps it to saturated pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one point (point_x/y/z, signed Q5.10) per transfer.
//   rsp_ch returns one result per point, in order: pixel_col, pixel_row and
//   behind_eye. A point at or behind the eye gives behind_eye = 1, pixels 0.
//   csr_we/csr_index/csr_wdata write the matrix rows, eye distance, gain,
//   screen origin and vertical aspect; write only while the pipe is empty.
// Timing:
//   A point enters every cycle while rsp_ch does not stall. The transfer
//   loads the first of 23 register stages: five arithmetic stages
//   (products, row sums, denominator and gain products, aspect product,
//   magnitudes), a 17-stage restoring divider, one quotient bit per stage,
//   then the output register.
// Reset and stall:
//   Synchronous reset empties the pipe and loads the identity matrix and the
//   default screen setup. When rsp_ch stalls with a result held, the whole
//   pipe freezes and req_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "perspective_point_projection_assert.svh"

module perspective_point_projection
   import ppp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ppp_stream_if.sink            req_ch,
   ppp_stream_if.source          rsp_ch,
   input  logic                  csr_we,
   input  logic [CsrIdxW-1:0]    csr_index,
   input  logic [CsrDataW-1:0]   csr_wdata
);

   // configuration registers
   logic [CsrDataW-1:0] rot_ff [3];
   logic [EyeW-1:0]     eye_ff;
   logic [GainW-1:0]    gain_ff;
   logic [OrgW-1:0]     xorg_ff;
   logic [OrgW-1:0]     yorg_ff;
   logic [AspW-1:0]     asp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 48'd16384;
         rot_ff[1] <= 48'd1073741824;
         rot_ff[2] <= 48'd70368744177664;
         eye_ff    <= 18'd31744;
         gain_ff   <= 24'd325632;
         xorg_ff   <= 10'd79;
         yorg_ff   <= 10'd44;
         asp_ff    <= 9'd205;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_ROW0:     rot_ff[0] <= csr_wdata;
            CSR_ROT_ROW1:     rot_ff[1] <= csr_wdata;
            CSR_ROT_ROW2:     rot_ff[2] <= csr_wdata;
            CSR_EYE_DISTANCE: eye_ff    <= csr_wdata[EyeW-1:0];
            CSR_PROJ_GAIN:    gain_ff   <= csr_wdata[GainW-1:0];
            CSR_SCREEN_X_ORG: xorg_ff   <= csr_wdata[OrgW-1:0];
            CSR_SCREEN_Y_ORG: yorg_ff   <= csr_wdata[OrgW-1:0];
            CSR_VERT_ASPECT:  asp_ff    <= csr_wdata[AspW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: move when the output register is empty or drained
   logic               adv;
   logic               acc_in;
   logic [NumStg-1:0]  vld_ff;

   assign adv          = !vld_ff[NumStg-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign acc_in       = req_ch.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NumStg-2:0], acc_in};
      end
   end

   // stage 1: nine coefficient products
   logic signed [ProdW-1:0] prd_ff [3][3];
   logic signed [PtW-1:0]   pt [3];

   assign pt[0] = req_ch.data.point_x;
   assign pt[1] = req_ch.data.point_y;
   assign pt[2] = req_ch.data.point_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prd_ff[r][c] <= $signed(rot_ff[r][CoefW*c +: CoefW]) * pt[c];
            end
         end
      end
   end

   // stage 2: row sums, floor to Q.10
   logic signed [AccW-1:0] acc [3];
   logic signed [RotW-1:0] rot_cmp_ff [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = AccW'(prd_ff[r][0]) + AccW'(prd_ff[r][1]) + AccW'(prd_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            rot_cmp_ff[r] <= acc[r][AccW-1:14];
         end
      end
   end

   // stage 3: denominator and gain products
   logic signed [DenFullW-1:0] den_full;
   logic [DenW-1:0]            den3_ff;
   logic                       beh3_ff;
   logic signed [PgW-1:0]      pg1_ff;
   logic signed [PgW-1:0]      pg2_ff;

   assign den_full = $signed({3'b000, eye_ff}) - DenFullW'(rot_cmp_ff[0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         den3_ff <= den_full[DenW-1:0];
         beh3_ff <= den_full[DenFullW-1] || (den_full == '0);
         pg1_ff  <= $signed({1'b0, gain_ff}) * rot_cmp_ff[1];
         pg2_ff  <= $signed({1'b0, gain_ff}) * rot_cmp_ff[2];
      end
   end

   // stage 4: column dividend, aspect product for the row
   logic signed [Num1W-1:0] num1_ff;
   logic signed [Pg2W-1:0]  pg3_ff;
   logic [DenW-1:0]         den4_ff;
   logic                    beh4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff <= pg1_ff[PgW-1:10];
         pg3_ff  <= pg2_ff * $signed({1'b0, asp_ff});
         den4_ff <= den3_ff;
         beh4_ff <= beh3_ff;
      end
   end

   // divider working set: index 0 is stage 5, index QBits feeds the output
   logic [MagW-1:0]  dmag_ff [QBits+1][2];
   logic [QBits-1:0] dq_ff   [QBits+1][2];
   logic             dneg_ff [QBits+1][2];
   logic             dovf_ff [QBits+1][2];
   logic [DenW-1:0]  dden_ff [QBits+1];
   logic             dbeh_ff [QBits+1];

   // stage 5: signed dividends to magnitude, overflow check
   logic signed [Num2W-1:0] num1_x;
   logic signed [Num2W-1:0] num2;
   logic signed [Pg2W-1:0]  pg3_neg;
   logic signed [Num2W-1:0] nabs [2];
   logic [MagW-1:0]         den_lim;

   always_comb begin
      pg3_neg = -pg3_ff;
      num2    = pg3_neg[Pg2W-1:18];
      num1_x  = Num2W'(num1_ff);
      nabs[0] = num1_x[Num2W-1] ? -num1_x : num1_x;
      nabs[1] = num2[Num2W-1] ? -num2 : num2;
      den_lim = {den4_ff, {QBits{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff[0][0] <= nabs[0][MagW-1:0];
         dmag_ff[0][1] <= nabs[1][MagW-1:0];
         dneg_ff[0][0] <= num1_x[Num2W-1];
         dneg_ff[0][1] <= num2[Num2W-1];
         dovf_ff[0][0] <= nabs[0][MagW-1:0] >= den_lim;
         dovf_ff[0][1] <= nabs[1][MagW-1:0] >= den_lim;
         dq_ff[0][0]   <= '0;
         dq_ff[0][1]   <= '0;
         dden_ff[0]    <= den4_ff;
         dbeh_ff[0]    <= beh4_ff;
      end
   end

   // restoring divider: one quotient bit per stage, most significant first
   for (genvar k = 0; k < QBits; k++) begin : g_div
      localparam int Bit = QBits - 1 - k;
      logic [MagW-1:0]  sub_val;
      logic [MagW-1:0]  mag_in [2];
      logic [QBits-1:0] q_in   [2];

      assign sub_val = MagW'(dden_ff[k]) << Bit;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (dmag_ff[k][l] >= sub_val) begin
               mag_in[l] = dmag_ff[k][l] - sub_val;
               q_in[l]   = dq_ff[k][l] | (QBits'(1) << Bit);
            end else begin
               mag_in[l] = dmag_ff[k][l];
               q_in[l]   = dq_ff[k][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 2; l++) begin
               dmag_ff[k+1][l] <= mag_in[l];
               dq_ff[k+1][l]   <= q_in[l];
               dneg_ff[k+1][l] <= dneg_ff[k][l];
               dovf_ff[k+1][l] <= dovf_ff[k][l];
            end
            dden_ff[k+1] <= dden_ff[k];
            dbeh_ff[k+1] <= dbeh_ff[k];
         end
      end
   end

   // output: floor sign fix, add origin, saturate
   logic signed [SumW-1:0] qs   [2];
   logic signed [SumW-1:0] sum  [2];
   logic signed [PixW-1:0] pix  [2];
   logic [OrgW-1:0]        org  [2];
   rsp_payload_type        out_ff;
   rsp_payload_type        out_in;

   assign org[0] = xorg_ff;
   assign org[1] = yorg_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qs[l] = $signed(SumW'(dq_ff[QBits][l]));
         if (dneg_ff[QBits][l]) begin
            qs[l] = -(qs[l] + SumW'(dmag_ff[QBits][l] != '0));
         end
         sum[l] = qs[l] + $signed(SumW'(org[l]));
         if (dovf_ff[QBits][l]) begin
            pix[l] = dneg_ff[QBits][l] ? 16'sh8000 : 16'sh7FFF;
         end else begin
            pix[l] = sat_pix(sum[l]);
         end
      end
      out_in.behind_eye = dbeh_ff[QBits];
      out_in.pixel_col  = dbeh_ff[QBits] ? '0 : pix[0];
      out_in.pixel_row  = dbeh_ff[QBits] ? '0 : pix[1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = vld_ff[NumStg-1];
   assign rsp_ch.data  = out_ff;

   // checks
   `PPP_ASSERT_IMP(a_behind_zero, clock, reset,
      rsp_ch.valid && rsp_ch.data.behind_eye,
      rsp_ch.data.pixel_col == '0 && rsp_ch.data.pixel_row == '0)
   `PPP_ASSERT_IMP(a_stall_blocks_input, clock, reset,
      rsp_ch.valid && !rsp_ch.ready, !req_ch.ready)
   `PPP_ASSERT_NXT(a_accept_enters, clock, reset,
      req_ch.valid && req_ch.ready, vld_ff[0])

endmodule
